// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the echo range gated moving average.
// Each macro samples on clk and is switched off while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ERG_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define ERG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/core/ergma_pkg.sv
// Package for the echo range gated moving average: widths, constants,
// register indexes and the window update struct. No dependencies.
package ergma_pkg;

  localparam int WINDOW      = 5;
  localparam int ECHO_W      = 20;
  localparam int DIST_W      = 15;
  localparam int SAMPLE_W    = 10;
  localparam int SAMPLE_MAX  = (1 << SAMPLE_W) - 1;
  localparam int TOTAL_W     = $clog2(WINDOW * SAMPLE_MAX + 1);
  localparam int SLOT_W      = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  // Pulse width to distance: floor(width * 1114 / 2^16), about 0.017 cm/us.
  localparam int SCALE_W     = 11;
  localparam int SCALE_SHIFT = 16;
  localparam int PROD_W      = ECHO_W + SCALE_W;
  localparam logic [SCALE_W-1:0] SCALE_MUL = 11'd1114;

  // Division by WINDOW as a multiply by a rounded-up reciprocal.
  localparam int AVG_SHIFT   = 20;
  localparam int RECIP_W     = AVG_SHIFT + 1;
  localparam int RECIP       = ((1 << AVG_SHIFT) + WINDOW - 1) / WINDOW;
  localparam int AVG_PROD_W  = TOTAL_W + RECIP_W;

  localparam logic [SAMPLE_W-1:0] MIN_DIST_RST = 10'd10;
  localparam logic [SAMPLE_W-1:0] MAX_DIST_RST = 10'd450;

  localparam int CFG_IDX_W   = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DIST = 2'd1;

  typedef struct packed {
    logic                write;
    logic [SAMPLE_W-1:0] sample;
  } win_upd_t;

endpackage

// File: rtl/core/ergma_window.sv
// Ring window of accepted distances with its running total.
// Depends on ergma_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ergma_window (
  input  logic                               clk,
  input  logic                               rst,
  input  ergma_pkg::win_upd_t                upd,
  output logic [ergma_pkg::TOTAL_W-1:0]      total
);

  logic [ergma_pkg::SAMPLE_W-1:0] samples [ergma_pkg::WINDOW];
  logic [ergma_pkg::SLOT_W-1:0]   slot;
  logic [ergma_pkg::SLOT_W-1:0]   slot_next;
  logic [ergma_pkg::TOTAL_W-1:0]  total_next;
  logic [ergma_pkg::SAMPLE_W-1:0] oldest;

  always_comb begin
    oldest     = samples[slot];
    total_next = total - ergma_pkg::TOTAL_W'(oldest)
                 + ergma_pkg::TOTAL_W'(upd.sample);
    slot_next  = (slot == ergma_pkg::SLOT_W'(ergma_pkg::WINDOW - 1)) ?
                 '0 : slot + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < ergma_pkg::WINDOW; i++) begin
        samples[i] <= '0;
      end
      slot  <= '0;
      total <= '0;
    end else if (upd.write) begin
      // Replace the oldest sample and advance
      samples[slot] <= upd.sample;
      slot          <= slot_next;
      total         <= total_next;
    end
  end

  `ERG_ASSERT(slot_in_window, 1'b1, slot <= ergma_pkg::SLOT_W'(ergma_pkg::WINDOW - 1), "write slot beyond window")
  `ERG_ASSERT(total_bounded, 1'b1, total <= ergma_pkg::TOTAL_W'(ergma_pkg::WINDOW * ergma_pkg::SAMPLE_MAX), "window total overflow")
  `ERG_ASSERT_NEXT(total_holds, !upd.write, total == $past(total) && slot == $past(slot), "window changed without a write")

endmodule

// File: rtl/core/echo_range_gated_moving_average.sv
// Echo range gated moving average: top level, four-stage pipeline.
// One item per cycle while the output is not stalled by m_tready.
// Stages: input register, distance multiply and range gate, window update,
// average by reciprocal multiply into the result register.
// Synchronous active-high reset: empty pipeline, window and total zero,
// limits 10 cm and 450 cm. Depends on ergma_pkg and ergma_window.
module echo_range_gated_moving_average (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [ergma_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ergma_pkg::SAMPLE_W-1:0]       cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  input  logic [23:0]                          s_tdata,  // [19:0] echo_width_us
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  output logic [31:0]                          m_tdata,  // [14:0] distance_cm, [24:15] average_cm
  output logic                                 m_tuser   // [0] in_range
);

  logic [ergma_pkg::SAMPLE_W-1:0] min_dist;
  logic [ergma_pkg::SAMPLE_W-1:0] max_dist;

  logic                           a_valid;
  logic [ergma_pkg::ECHO_W-1:0]   a_width;
  logic                           b_valid;
  logic [ergma_pkg::DIST_W-1:0]   b_dist;
  logic                           b_ok;
  logic                           c_valid;
  logic [ergma_pkg::DIST_W-1:0]   c_dist;
  logic                           c_ok;
  logic                           d_valid;
  logic [ergma_pkg::DIST_W-1:0]   d_dist;
  logic                           d_ok;
  logic [ergma_pkg::SAMPLE_W-1:0] d_avg;

  logic a_ready, b_ready, c_ready, d_ready;
  logic a_load, b_load, c_load, d_load;

  logic [ergma_pkg::PROD_W-1:0]     prod;
  logic [ergma_pkg::DIST_W-1:0]     dist_cm;
  logic                             ok;
  logic [ergma_pkg::TOTAL_W-1:0]    total;
  logic [ergma_pkg::AVG_PROD_W-1:0] avg_prod;
  ergma_pkg::win_upd_t              upd;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_dist <= ergma_pkg::MIN_DIST_RST;
      max_dist <= ergma_pkg::MAX_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ergma_pkg::CFG_MIN_DIST: min_dist <= cfg_data;
        ergma_pkg::CFG_MAX_DIST: max_dist <= cfg_data;
        default: ;
      endcase
    end
  end

  // Each stage takes a new item when empty or when its own item moves on
  always_comb begin
    d_ready = !d_valid || m_tready;
    c_ready = !c_valid || d_ready;
    b_ready = !b_valid || c_ready;
    a_ready = !a_valid || b_ready;
    a_load  = s_tvalid && a_ready;
    b_load  = a_valid && b_ready;
    c_load  = b_valid && c_ready;
    d_load  = c_valid && d_ready;
  end

  assign s_tready = a_ready;

  always_comb begin
    prod    = ergma_pkg::PROD_W'(a_width) * ergma_pkg::PROD_W'(ergma_pkg::SCALE_MUL);
    dist_cm = prod[ergma_pkg::SCALE_SHIFT +: ergma_pkg::DIST_W];
    ok      = (dist_cm >= ergma_pkg::DIST_W'(min_dist)) &&
              (dist_cm <= ergma_pkg::DIST_W'(max_dist));
  end

  // Accepted distances never exceed the 10-bit upper limit
  assign upd.write  = c_load && b_ok;
  assign upd.sample = b_dist[ergma_pkg::SAMPLE_W-1:0];

  ergma_window u_window (
    .clk   (clk),
    .rst   (rst),
    .upd   (upd),
    .total (total)
  );

  // The window only changes on a load into stage c, so total belongs to c's item
  assign avg_prod = ergma_pkg::AVG_PROD_W'(total) *
                    ergma_pkg::AVG_PROD_W'(ergma_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
      d_valid <= 1'b0;
    end else begin
      if (a_ready) a_valid <= s_tvalid;
      if (b_ready) b_valid <= a_valid;
      if (c_ready) c_valid <= b_valid;
      if (d_ready) d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (a_load) begin
      a_width <= s_tdata[ergma_pkg::ECHO_W-1:0];
    end
    if (b_load) begin
      b_dist <= dist_cm;
      b_ok   <= ok;
    end
    if (c_load) begin
      c_dist <= b_dist;
      c_ok   <= b_ok;
    end
    if (d_load) begin
      d_dist <= c_dist;
      d_ok   <= c_ok;
      d_avg  <= avg_prod[ergma_pkg::AVG_SHIFT +: ergma_pkg::SAMPLE_W];
    end
  end

  assign m_tvalid = d_valid;
  assign m_tdata  = {7'b0, d_avg, d_dist};
  assign m_tuser  = d_ok;

endmodule

// File: tb/sv/echo_range_gated_moving_average_tb.sv
// Testbench for echo_range_gated_moving_average: random and directed echo widths
// through the stream ports, checked against a predictor kept in a scoreboard class.
// Depends on ergma_pkg and the RTL of the block.
module echo_range_gated_moving_average_tb;
  import ergma_pkg::*;

  localparam int ECHO_MAX    = (1 << ECHO_W) - 1;
  localparam int CM_PER_US_Q = 1114;   // cm per us, 16 fractional bits
  localparam int Q_SHIFT     = 16;
  localparam int LATENCY     = 3;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                in_range;
    logic [DIST_W-1:0]   distance_cm;
    logic [SAMPLE_W-1:0] average_cm;
  } range_result_t;

  class range_average_scoreboard;
    logic [SAMPLE_W-1:0] window_cm [WINDOW];
    logic [SLOT_W-1:0]   slot;
    logic [TOTAL_W-1:0]  total_cm;
    logic [SAMPLE_W-1:0] min_cm;
    logic [SAMPLE_W-1:0] max_cm;
    range_result_t       pending_results [$];
    int                  errors;

    function new();
      foreach (window_cm[i]) window_cm[i] = '0;
      slot     = '0;
      total_cm = '0;
      min_cm   = 10'd10;
      max_cm   = 10'd450;
      errors   = 0;
    endfunction

    function void set_limit(logic [CFG_IDX_W-1:0] idx, logic [SAMPLE_W-1:0] val);
      if (idx == CFG_MIN_DIST) min_cm = val;
      else if (idx == CFG_MAX_DIST) max_cm = val;
    endfunction

    // Convert, gate and update the window; queue what the block must answer.
    function void note_echo(logic [ECHO_W-1:0] width_us);
      longint unsigned prod;
      logic [DIST_W-1:0] dist_cm;
      range_result_t r;
      prod = longint'(width_us) * CM_PER_US_Q;
      dist_cm = DIST_W'(prod >> Q_SHIFT);
      r.in_range    = (dist_cm >= DIST_W'(min_cm)) && (dist_cm <= DIST_W'(max_cm));
      r.distance_cm = dist_cm;
      if (r.in_range) begin
        total_cm = total_cm - window_cm[slot] + TOTAL_W'(dist_cm[SAMPLE_W-1:0]);
        window_cm[slot] = dist_cm[SAMPLE_W-1:0];
        slot = (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
      end
      r.average_cm = SAMPLE_W'(total_cm / WINDOW);
      pending_results.push_back(r);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(logic ok, logic [DIST_W-1:0] dist_cm, logic [SAMPLE_W-1:0] avg);
      range_result_t e;
      if (pending_results.size() == 0) begin
        report($sformatf("unexpected result in_range %0b dist %0d avg %0d",
                         ok, dist_cm, avg));
        return;
      end
      e = pending_results.pop_front();
      if (ok !== e.in_range)
        report($sformatf("in_range %0b, want %0b (dist %0d)", ok, e.in_range, e.distance_cm));
      if (dist_cm !== e.distance_cm)
        report($sformatf("distance_cm %0d, want %0d", dist_cm, e.distance_cm));
      if (avg !== e.average_cm)
        report($sformatf("average_cm %0d, want %0d", avg, e.average_cm));
    endtask
  endclass

  logic                 clk;
  logic                 rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [SAMPLE_W-1:0]  cfg_data;
  logic                 s_tvalid;
  logic                 s_tready;
  logic [23:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  logic [31:0]          m_tdata;
  logic                 m_tuser;

  range_average_scoreboard sb = new();

  int send_idle_pct = 15;
  int recv_idle_pct = 76;
  bit hold_request  = 0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  echo_range_gated_moving_average dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Smallest echo width that maps to the given distance.
  function automatic longint width_for(int unsigned d_cm);
    return (longint'(d_cm) * 65536 + CM_PER_US_Q - 1) / CM_PER_US_Q;
  endfunction

  // Mostly widths within the gate range widened by 3 cm; some span the whole field, the rest are short.
  function automatic logic [ECHO_W-1:0] pick_echo(int lo_cm, int hi_cm);
    int unsigned roll;
    int lo;
    int hi;
    longint w;
    roll = $urandom_range(99);
    lo = (lo_cm < hi_cm) ? lo_cm : hi_cm;
    hi = (lo_cm < hi_cm) ? hi_cm : lo_cm;
    lo = (lo > 3) ? lo - 3 : 0;
    hi = hi + 3;
    if (roll < 60) begin
      w = width_for($urandom_range(hi, lo)) + $urandom_range(65);
    end else if (roll < 85) begin
      w = $urandom_range(ECHO_MAX);
    end else begin
      w = $urandom_range(1023);
    end
    if (w > ECHO_MAX) w = ECHO_MAX;
    return ECHO_W'(w);
  endfunction

  task automatic send_echo(input longint width);
    logic [ECHO_W-1:0] w;
    w = ECHO_W'((width > ECHO_MAX) ? ECHO_MAX : width);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata  = {4'b0, ECHO_W'($urandom)};
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata  = {4'b0, w};
    do @(posedge clk); while (!s_tready);
    sb.note_echo(w);
  endtask

  task automatic send_random(input int count);
    for (int i = 0; i < count; i++) send_echo(pick_echo(sb.min_cm, sb.max_cm));
  endtask

  // Drop valid and wait until every item has come out of the pipeline.
  task automatic drain();
    @(negedge clk);
    s_tvalid = 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [SAMPLE_W-1:0] val);
    @(negedge clk);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    sb.set_limit(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_limits(input int lo_cm, input int hi_cm);
    write_reg(CFG_MIN_DIST, SAMPLE_W'(lo_cm));
    write_reg(CFG_MAX_DIST, SAMPLE_W'(hi_cm));
  endtask

  // Receiver: random stalls, plus a long hold-off on request.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left    = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready = 1'b0;
      end else begin
        m_tready = ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tuser, m_tdata[DIST_W-1:0], m_tdata[DIST_W+SAMPLE_W-1:DIST_W]);
    if (rst || cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int lo;
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset limits: timeout, widest echo, both gate edges, window wrap.
    send_echo(0);
    send_echo(ECHO_MAX);
    send_echo(width_for(10) - 1);
    send_echo(width_for(10));
    send_echo(width_for(450));
    send_echo(width_for(451) - 1);
    send_echo(width_for(451));
    for (int i = 0; i < 6; i++) send_echo(width_for(40 + 70 * i));
    drain();

    // Full range: timeout accepted, window saturated at the top sample.
    set_limits(0, 1023);
    send_echo(0);
    for (int i = 0; i < 5; i++) send_echo(width_for(1023) + i);
    send_echo(width_for(1024));
    drain();

    // Spare indexes are ignored; inverted limits accept nothing.
    write_reg(CFG_SPARE_A, 10'd0);
    write_reg(CFG_SPARE_B, 10'd1023);
    set_limits(500, 100);
    send_echo(width_for(300));
    send_echo(width_for(500));
    send_echo(width_for(100));
    drain();

    send_idle_pct = 15;
    recv_idle_pct = 76;
    set_limits(10, 450);
    send_random(300);
    drain();
    set_limits(0, 1023);
    send_random(280);
    drain();

    send_idle_pct = 76;
    recv_idle_pct = 15;
    lo = $urandom_range(1023);
    set_limits(lo, $urandom_range(1023, lo));
    send_random(300);
    drain();
    set_limits(1023, 1023);
    send_random(100);
    drain();
    set_limits(0, 0);
    send_random(100);
    drain();

    // No idling; hold the receiver off so the pipeline backs up.
    send_idle_pct = 0;
    recv_idle_pct = 0;
    set_limits(200, 700);
    hold_request = 1'b1;
    send_random(300);
    drain();
    set_limits($urandom_range(1023), $urandom_range(1023));
    send_random(270);
    drain();

    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
